[src/newton_square_root_macros.svh]
// ----------------------------------------------------------------------------
// newton square root assertion macros
// shared property forms for the block's concurrent checks, sampled on clk
// and held off while rst_n is low
// ----------------------------------------------------------------------------
`ifndef NEWTON_SQUARE_ROOT_MACROS_SVH
`define NEWTON_SQUARE_ROOT_MACROS_SVH

// same-cycle implication
`define NSR_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nsr assertion failed");

// next-cycle implication
`define NSR_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nsr assertion failed");

`endif

[src/nsr_pkg.sv]
// ----------------------------------------------------------------------------
// nsr_pkg
// widths, register codes and controller/datapath interface types
// ----------------------------------------------------------------------------
package nsr_pkg;

    localparam int FRAC_BITS   = 30;             // fraction bits of the estimate
    localparam int IN_FRAC     = 29;             // fraction bits of the input
    localparam int IN_W        = 33;             // value field
    localparam int X_W         = IN_W + FRAC_BITS - IN_FRAC; // aligned input
    localparam int DVD_W       = 64;             // dividend x << FRAC_BITS
    localparam int EST_W       = 62;             // estimate and quotient
    localparam int REM_W       = EST_W;          // division remainder
    localparam int DIV_CNT_W   = 6;              // step index of the divider
    localparam int ROOT_W      = 32;
    localparam int CNT_W       = 6;
    localparam int TOL_W       = 30;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = TOL_W;
    localparam int S_TDATA_W   = 40;
    localparam int M_TDATA_W   = 40;

    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ITER_LIMIT = 1'd1;

    localparam logic [TOL_W-1:0] TOL_RESET   = 30'd107374;
    localparam logic [CNT_W-1:0] LIMIT_RESET = 6'd16;

    // largest input, 8.0 in Q4.29
    localparam logic [IN_W-1:0] VALUE_MAX = 33'h1_0000_0000;

    typedef struct packed {
        logic load_in;     // take a new value, reset estimate and count
        logic start_div;   // launch x / est
        logic sum;         // form the averaged estimate
        logic step;        // commit the new estimate, bump the count
        logic hit_load;    // write the limit flag
        logic hit_val;
        logic load_out;    // copy the result into the output register
    } nsr_cmd_t;

    typedef struct packed {
        logic est_zero;    // zero input, nothing to iterate
        logic at_limit;    // update count reached the limit
        logic div_done;    // quotient ready
        logic converged;   // last update within tolerance
    } nsr_stat_t;

endpackage

[src/nsr_divider.sv]
// ----------------------------------------------------------------------------
// nsr_divider
// restoring bit-serial divider, one quotient bit per cycle, saturated result
// ----------------------------------------------------------------------------
module nsr_divider
    import nsr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [EST_W-1:0] divisor,
    output logic             done,
    output logic [EST_W-1:0] quotient
);

    logic                 busy_reg,  busy_next;
    logic                 done_reg,  done_next;
    logic [DIV_CNT_W-1:0] cnt_reg,   cnt_next;
    logic [DVD_W-1:0]     dvd_reg,   dvd_next;   // dividend bits out, quotient bits in
    logic [REM_W-1:0]     rem_reg,   rem_next;
    logic [EST_W-1:0]     dsr_reg,   dsr_next;
    logic [REM_W:0]       trial;
    logic                 fits;

    assign trial = {rem_reg, dvd_reg[DVD_W-1]};
    assign fits  = trial >= {1'b0, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? REM_W'(trial - {1'b0, dsr_reg}) : trial[REM_W-1:0];
            dvd_next = {dvd_reg[DVD_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == '1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    // quotient bits at or above 2^62 saturate
    assign done     = done_reg;
    assign quotient = (dvd_reg[DVD_W-1:EST_W] != '0) ? '1 : dvd_reg[EST_W-1:0];

endmodule

[src/nsr_datapath.sv]
// ----------------------------------------------------------------------------
// nsr_datapath
// estimate, update count, newton step arithmetic and output register
// ----------------------------------------------------------------------------
module nsr_datapath
    import nsr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  nsr_cmd_t         cmd,
    output nsr_stat_t        stat,
    input  logic [IN_W-1:0]  value,
    input  logic [TOL_W-1:0] tolerance,
    input  logic [CNT_W-1:0] iteration_limit,
    output logic [M_TDATA_W-1:0] result
);

    logic [EST_W-1:0]  est_reg,   est_next;
    logic [EST_W-1:0]  nxt_reg,   nxt_next;
    logic [X_W-1:0]    x_reg,     x_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              hit_reg,   hit_next;
    logic [M_TDATA_W-1:0] out_reg, out_next;

    logic [IN_W-1:0]   v_sat;
    logic [EST_W:0]    est_sum;
    logic [EST_W-1:0]  diff;
    logic [EST_W-1:0]  quotient;
    logic [ROOT_W-1:0] root;

    nsr_divider u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.start_div),
        .dividend ({x_reg, {FRAC_BITS{1'b0}}}),
        .divisor  (est_reg),
        .done     (stat.div_done),
        .quotient (quotient)
    );

    assign v_sat   = (value > VALUE_MAX) ? VALUE_MAX : value;
    assign est_sum = {1'b0, est_reg} + {1'b0, quotient};
    assign diff    = (nxt_reg > est_reg) ? nxt_reg - est_reg : est_reg - nxt_reg;
    assign root    = (est_reg[EST_W-1:ROOT_W] != '0) ? '1 : est_reg[ROOT_W-1:0];

    always_comb
    begin
        x_next     = x_reg;
        est_next   = est_reg;
        nxt_next   = nxt_reg;
        count_next = count_reg;
        hit_next   = hit_reg;
        out_next   = out_reg;
        if (cmd.load_in)
        begin
            // align Q4.29 to the estimate's fraction
            x_next     = {v_sat, {(FRAC_BITS - IN_FRAC){1'b0}}};
            est_next   = EST_W'(x_next);
            count_next = '0;
        end
        if (cmd.sum)
        begin
            nxt_next = (est_sum[EST_W:1] == '0) ? EST_W'(1) : est_sum[EST_W:1];
        end
        if (cmd.step)
        begin
            est_next   = nxt_reg;
            count_next = count_reg + 1'b1;
        end
        if (cmd.hit_load)
        begin
            hit_next = cmd.hit_val;
        end
        if (cmd.load_out)
        begin
            out_next = M_TDATA_W'({hit_reg, count_reg, root});
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg     <= x_next;
        est_reg   <= est_next;
        nxt_reg   <= nxt_next;
        count_reg <= count_next;
        hit_reg   <= hit_next;
        out_reg   <= out_next;
    end

    assign stat.est_zero  = (est_reg == '0);
    assign stat.at_limit  = (count_reg >= iteration_limit);
    assign stat.converged = (diff <= {{(EST_W - TOL_W){1'b0}}, tolerance});
    assign result         = out_reg;

endmodule

[src/nsr_ctrl.sv]
// ----------------------------------------------------------------------------
// nsr_ctrl
// sequencer for the newton loop and both handshakes
// ----------------------------------------------------------------------------
module nsr_ctrl
    import nsr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    output nsr_cmd_t  cmd,
    input  nsr_stat_t stat
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CHECK  = 3'd1;
    localparam logic [2:0] ST_DIV    = 3'd2;
    localparam logic [2:0] ST_SUM    = 3'd3;
    localparam logic [2:0] ST_TEST   = 3'd4;
    localparam logic [2:0] ST_FINISH = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       ovalid_reg, ovalid_next;
    logic       out_free;

    assign out_free = !ovalid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (stat.est_zero)
                begin
                    cmd.hit_load = 1'b1;
                    cmd.hit_val  = 1'b0;
                    state_next   = ST_FINISH;
                end
                else if (stat.at_limit)
                begin
                    cmd.hit_load = 1'b1;
                    cmd.hit_val  = 1'b1;
                    state_next   = ST_FINISH;
                end
                else
                begin
                    cmd.start_div = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (stat.div_done)
                begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = ST_TEST;
            end
            ST_TEST:
            begin
                cmd.step = 1'b1;
                if (stat.converged)
                begin
                    cmd.hit_load = 1'b1;
                    cmd.hit_val  = 1'b0;
                    state_next   = ST_FINISH;
                end
                else
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ovalid_next = ovalid_reg;
        if (cmd.load_out)
        begin
            ovalid_next = 1'b1;
        end
        else if (out_ready)
        begin
            ovalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    assign out_valid = ovalid_reg;

`include "newton_square_root_macros.svh"

    // the divider only reports while the sequencer waits for it
    `NSR_ASSERT_IMP(a_done_in_div, stat.div_done, state_reg == ST_DIV)
    // a division is never running once the count is at the limit
    `NSR_ASSERT_IMP(a_div_below_limit, state_reg == ST_DIV, !stat.at_limit)
    // a finished result always reaches the output register
    `NSR_ASSERT_NXT(a_finish_to_out, state_reg == ST_FINISH && out_free, out_valid)
    // a new value is never taken together with an output load or a division start
    `NSR_ASSERT_IMP(a_load_clean, cmd.load_in, !cmd.load_out && !cmd.start_div)

endmodule

[src/newton_square_root.sv]
// ----------------------------------------------------------------------------
// newton_square_root
// newton-raphson square root of an unsigned Q4.29 value, result in Q2.30
// ----------------------------------------------------------------------------
// One value is worked on at a time. After a transaction on the s_ side the
// block starts from est = x and repeats est = (est + x/est)/2 until one
// update moves the estimate by no more than the tolerance register, or until
// iteration_limit updates are done (limit_hit then reads 1). Each update
// runs the bit-serial divider, forming x/est one quotient bit per cycle, and
// then averages the estimate and tests the update; a zero value skips the
// loop and goes straight to its result with a zero root. Inputs above 8.0
// are taken as 8.0 and roots above 2^32-1 are clipped. The result sits in an
// output register, so the next value is accepted while a result still waits
// on m_tready. Write the two registers only while the block is idle.
// ----------------------------------------------------------------------------
module newton_square_root
    import nsr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // value [32:0], zero fill [39:33]
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // root [31:0], iterations [37:32], limit_hit [38], zero fill [39]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,
    // register writes: index 0 tolerance, index 1 iteration_limit
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [TOL_W-1:0] tol_reg,   tol_next;
    logic [CNT_W-1:0] limit_reg, limit_next;
    nsr_cmd_t         cmd;
    nsr_stat_t        stat;

    // configuration registers, write only
    always_comb
    begin
        tol_next   = tol_reg;
        limit_next = limit_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_TOLERANCE:  tol_next   = cfg_data;
                REG_ITER_LIMIT: limit_next = cfg_data[CNT_W-1:0];
                default:        tol_next   = tol_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg   <= TOL_RESET;
            limit_reg <= LIMIT_RESET;
        end
        else
        begin
            tol_reg   <= tol_next;
            limit_reg <= limit_next;
        end
    end

    // sequencer: loop control and both handshakes
    nsr_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .cmd       (cmd),
        .stat      (stat)
    );

    // estimate, divider and output register
    nsr_datapath u_dp
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .value           (s_tdata[IN_W-1:0]),
        .tolerance       (tol_reg),
        .iteration_limit (limit_reg),
        .result          (m_tdata)
    );

endmodule

[verif/tb_newton_square_root.sv]
// ----------------------------------------------------------------------------
// tb_newton_square_root
// self-checking bench for the newton-raphson square root: a directed table of
// edge values and register settings, then random values over several register
// phases, each result checked per field against a typed row or bit-true predictor
// ----------------------------------------------------------------------------
module tb_newton_square_root
    import nsr_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    // quotient cap of the wide divide and the clip of the root field
    localparam logic [63:0]       QUOT_CAP  = 64'h3FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0]       ROOT_CLIP = 64'h0000_0000_FFFF_FFFF;
    localparam logic [TOL_W-1:0]  TOL_MAX   = 30'h3FFF_FFFF;
    localparam logic [CNT_W-1:0]  LIMIT_MAX = 6'd63;
    localparam logic [IN_W-1:0]   ONE_Q329  = 33'h0_2000_0000;
    localparam int DIR_ROWS      = 22;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 50;
    localparam int HOLD_CYCLES   = 3000;   // long receiver hold-off
    localparam int TAIL_CYCLES   = 100;    // quiet time after the last result

    typedef struct packed {
        logic [ROOT_W-1:0] root;
        logic [CNT_W-1:0]  iterations;
        logic              limit_hit;
    } root_result_t;

    // one row of the directed table; known rows carry their result typed in
    typedef struct packed {
        logic [TOL_W-1:0] tol;
        logic [CNT_W-1:0] lim;
        logic [IN_W-1:0]  value;
        logic             known;
        root_result_t     res;
    } stim_row_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // expected results in acceptance order
    root_result_t      root_expect_q [$];
    // bench copy of the two registers
    logic [TOL_W-1:0]  tol_now   = TOL_RESET;
    logic [CNT_W-1:0]  limit_now = LIMIT_RESET;

    int unsigned err_count  = 0;
    int unsigned burst_left = 1;
    bit          offering   = 1'b0;
    bit          hold_req   = 1'b0;   // set by the stimulus
    bit          hold_done  = 1'b0;   // set by the receiver

    newton_square_root DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // directed table: reset settings first, then the register extremes
    // (zero limit, single update, zero tolerance, widest and tightest tolerance)
    stim_row_t stim_table [DIR_ROWS] = '{
        // reset settings: zero, 8.0, above 8.0, tiny, exact 1.0, 4.0, just under 8.0
        '{TOL_RESET, LIMIT_RESET, 33'h0_0000_0000, 1'b1, '{32'h0000_0000, 6'd0, 1'b0}},
        '{TOL_RESET, LIMIT_RESET, 33'h1_0000_0000, 1'b0, '{32'h0, 6'd0, 1'b0}},
        '{TOL_RESET, LIMIT_RESET, 33'h1_FFFF_FFFF, 1'b0, '{32'h0, 6'd0, 1'b0}},
        '{TOL_RESET, LIMIT_RESET, 33'h0_0000_0001, 1'b0, '{32'h0, 6'd0, 1'b0}},
        '{TOL_RESET, LIMIT_RESET, ONE_Q329,        1'b1, '{32'h4000_0000, 6'd1, 1'b0}},
        '{TOL_RESET, LIMIT_RESET, 33'h0_8000_0000, 1'b0, '{32'h0, 6'd0, 1'b0}},
        '{TOL_RESET, LIMIT_RESET, 33'h0_FFFF_FFFF, 1'b0, '{32'h0, 6'd0, 1'b0}},
        // zero limit: start estimate comes back, flagged; zero input still clean
        '{TOL_RESET, 6'd0, 33'h0_0000_0000, 1'b1, '{32'h0000_0000, 6'd0, 1'b0}},
        '{TOL_RESET, 6'd0, ONE_Q329,        1'b1, '{32'h4000_0000, 6'd0, 1'b1}},
        '{TOL_RESET, 6'd0, 33'h1_0000_0000, 1'b1, '{32'hFFFF_FFFF, 6'd0, 1'b1}},
        // one update: converging on the last one is not a limit hit
        '{TOL_RESET, 6'd1, ONE_Q329,        1'b1, '{32'h4000_0000, 6'd1, 1'b0}},
        '{TOL_RESET, 6'd1, 33'h1_0000_0000, 1'b1, '{32'hFFFF_FFFF, 6'd1, 1'b1}},
        // zero tolerance: only a fixed point converges
        '{30'd0, LIMIT_MAX, ONE_Q329,        1'b1, '{32'h4000_0000, 6'd1, 1'b0}},
        '{30'd0, LIMIT_MAX, 33'h0_C000_0000, 1'b0, '{32'h0, 6'd0, 1'b0}},
        '{30'd0, LIMIT_MAX, 33'h0_0000_0003, 1'b0, '{32'h0, 6'd0, 1'b0}},
        '{30'd0, LIMIT_MAX, 33'h1_0000_0000, 1'b0, '{32'h0, 6'd0, 1'b0}},
        // widest tolerance
        '{TOL_MAX, LIMIT_MAX, 33'h1_0000_0000, 1'b0, '{32'h0, 6'd0, 1'b0}},
        '{TOL_MAX, LIMIT_MAX, 33'h0_0000_0001, 1'b0, '{32'h0, 6'd0, 1'b0}},
        '{TOL_MAX, LIMIT_MAX, 33'h0_4000_0000, 1'b0, '{32'h0, 6'd0, 1'b0}},
        // tightest nonzero tolerance
        '{30'd1, LIMIT_MAX, 33'h0_0000_0001, 1'b0, '{32'h0, 6'd0, 1'b0}},
        '{30'd1, LIMIT_MAX, 33'h1_0000_0000, 1'b0, '{32'h0, 6'd0, 1'b0}},
        '{30'd1, LIMIT_MAX, 33'h0_0000_0000, 1'b1, '{32'h0000_0000, 6'd0, 1'b0}}
    };

    // bit-true newton iteration: est <- (est + x/est) / 2 on Q2.30
    function automatic root_result_t predict_root(input logic [IN_W-1:0]  value,
                                                  input logic [TOL_W-1:0] tol,
                                                  input logic [CNT_W-1:0] lim);
        root_result_t r;
        logic [IN_W-1:0] v;
        logic [63:0] x, est, q, nxt, diff;
        int unsigned count;
        bit conv;
        v = (value > VALUE_MAX) ? VALUE_MAX : value;   // inputs above 8.0 clamp
        r = '0;
        if (v == '0)
            return r;
        x = 64'(v) << (FRAC_BITS - IN_FRAC);
        est = x;
        count = 0;
        conv = 1'b0;
        while (count < lim && !conv)
        begin
            q = (x << FRAC_BITS) / est;
            if (q > QUOT_CAP)
                q = QUOT_CAP;
            nxt = (est + q) >> 1;
            if (nxt == 64'd0)
                nxt = 64'd1;
            diff = (nxt > est) ? nxt - est : est - nxt;
            est = nxt;
            count++;
            if (diff <= 64'(tol))
                conv = 1'b1;
        end
        r.root       = (est > ROOT_CLIP) ? ROOT_CLIP[ROOT_W-1:0] : est[ROOT_W-1:0];
        r.iterations = CNT_W'(count);
        r.limit_hit  = !conv;
        return r;
    endfunction

    // value mix: zero, 8.0, above 8.0, tiny, powers of two, full range
    function automatic logic [IN_W-1:0] random_value();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return VALUE_MAX;
            2: return {1'b1, 32'($urandom)};
            3: return IN_W'($urandom_range(1, 255));
            4: return IN_W'(1) << $urandom_range(0, 32);
            default: return {1'b0, 32'($urandom)};
        endcase
    endfunction

    // spread over many decades rather than piling up near the top
    function automatic logic [TOL_W-1:0] random_tolerance();
        logic [TOL_W-1:0] t;
        t = TOL_W'($urandom_range(1, 32'h3FFF_FFFF) >> $urandom_range(0, 29));
        return (t == '0) ? TOL_W'(1) : t;
    endfunction

    // one value transaction; the sender goes idle at the end of each burst
    task automatic send_value(input logic [IN_W-1:0] value, input bit known,
                              input root_result_t known_res);
        int unsigned gap;
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'(value);
        offering  = 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        root_expect_q.push_back(known ? known_res
                                      : predict_root(value, tol_now, limit_now));
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            // mostly short gaps, now and then a long one so the block goes idle
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 600)
                                               : $urandom_range(1, 12);
            s_tvalid <= 1'b0;
            s_tdata  <= S_TDATA_W'({$urandom, $urandom});
            offering  = 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 8);
        end
    endtask

    // stop offering and let every pending result come out
    task automatic wait_results_drained();
        if (offering)
        begin
            s_tvalid <= 1'b0;
            offering  = 1'b0;
        end
        while (root_expect_q.size() != 0)
            @(posedge clk);
    endtask

    // both registers, only while the block is idle; junk above the limit field
    task automatic write_registers(input logic [TOL_W-1:0] tol,
                                   input logic [CNT_W-1:0] lim);
        cfg_we    <= 1'b1;
        cfg_index <= REG_TOLERANCE;
        cfg_data  <= CFG_DATA_W'(tol);
        @(posedge clk);
        cfg_index <= REG_ITER_LIMIT;
        cfg_data  <= (CFG_DATA_W'($urandom) << CNT_W) | CFG_DATA_W'(lim);
        @(posedge clk);
        cfg_we    <= 1'b0;
        tol_now   = tol;
        limit_now = lim;
    endtask

    // main stimulus
    initial
    begin
        logic [TOL_W-1:0] tol;
        logic [CNT_W-1:0] lim;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed table; a register change waits for the block to go idle
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            if (stim_table[i].tol != tol_now || stim_table[i].lim != limit_now)
            begin
                wait_results_drained();
                write_registers(stim_table[i].tol, stim_table[i].lim);
            end
            send_value(stim_table[i].value, stim_table[i].known, stim_table[i].res);
        end

        // random phases, the register extremes among them
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: begin tol = TOL_RESET;  lim = LIMIT_RESET; end
                1: begin tol = 30'd1;      lim = LIMIT_MAX;   end
                2: begin tol = TOL_MAX;    lim = 6'd1;        end
                3: begin tol = 30'd0;      lim = LIMIT_MAX;   end
                default:
                begin
                    tol = random_tolerance();
                    lim = CNT_W'($urandom_range(1, 63));
                end
            endcase
            wait_results_drained();
            write_registers(tol, lim);
            // receiver holds off while the sender keeps offering
            if (p == 4)
                hold_req = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // sender pauses until the pipeline is empty
                if (p == 2 && n == PHASE_ITEMS / 2)
                    wait_results_drained();
                send_value(random_value(), 1'b0, '0);
            end
        end

        wait_results_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // receiver: stretches of always ready, coin flips and rare ready,
    // plus one long hold-off on request
    initial
    begin
        int unsigned mode;
        int unsigned len;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_req && !hold_done)
            begin
                repeat (HOLD_CYCLES)
                begin
                    @(posedge clk);
                    m_tready <= 1'b0;
                end
                hold_done = 1'b1;
            end
            mode = $urandom_range(0, 2);
            len  = $urandom_range(20, 300);
            repeat (len)
            begin
                @(posedge clk);
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    default: m_tready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    // result check: each result transaction against the oldest expectation
    always @(posedge clk)
    begin : check_results
        root_result_t want;
        root_result_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.root       = m_tdata[ROOT_W-1:0];
            got.iterations = m_tdata[ROOT_W +: CNT_W];
            got.limit_hit  = m_tdata[ROOT_W + CNT_W];
            if (root_expect_q.size() == 0)
            begin
                $error("unexpected result transaction: root %h", got.root);
                err_count++;
            end
            else
            begin
                want = root_expect_q.pop_front();
                if (got.root !== want.root)
                begin
                    $error("root: expected %h, actual %h", want.root, got.root);
                    err_count++;
                end
                if (got.iterations !== want.iterations)
                begin
                    $error("iterations: expected %0d, actual %0d",
                           want.iterations, got.iterations);
                    err_count++;
                end
                if (got.limit_hit !== want.limit_hit)
                begin
                    $error("limit_hit: expected %b, actual %b",
                           want.limit_hit, got.limit_hit);
                    err_count++;
                end
            end
        end
    end

    // watchdog, several times the slowest legal run
    initial
    begin
        #(80_000_000);
        $display("Regression FAIL");
        $finish;
    end

endmodule
